@@ rtl/core/fffl_pkg.sv @@
// shared types and constants for the first-fit free-list object table
// no dependencies
package fffl_pkg;

    localparam logic [1:0] ACT_PUT    = 2'd0;
    localparam logic [1:0] ACT_LOOKUP = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ZERO_SIZE = 3'd1;
    localparam logic [2:0] ST_NO_SPACE  = 3'd2;
    localparam logic [2:0] ST_NO_SLOT   = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_LIST_FULL = 3'd5;

    // free-row operation broadcast to every cell
    typedef enum logic [1:0] {
        FOP_NONE,
        FOP_SPLIT,
        FOP_TAKE,
        FOP_PUSH
    } fop_t;

    typedef struct packed {
        fop_t        op;
        logic [32:0] need;
        logic [31:0] push_offset;
        logic [32:0] push_size;
    } free_cmd_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] offset;
        logic [32:0] size;
    } free_blk_t;

endpackage

@@ rtl/core/fffl_free_cell.sv @@
// one cell of the ordered free-block row
// depends on fffl_pkg
module fffl_free_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 rst_valid,
    input  logic [32:0]          rst_size,
    input  fffl_pkg::free_cmd_t  cmd,
    input  logic                 sel,      // this cell is the first fit
    input  logic                 sel_seen, // an earlier cell is the first fit
    input  fffl_pkg::free_blk_t  prev_blk,
    input  fffl_pkg::free_blk_t  next_blk,
    input  logic                 is_first,
    output fffl_pkg::free_blk_t  blk,
    output logic                 fits
);
    import fffl_pkg::*;

    free_blk_t blk_reg, blk_next;

    assign blk  = blk_reg;
    assign fits = blk_reg.valid && (blk_reg.size >= cmd.need);

    always_comb begin
        blk_next = blk_reg;
        case (cmd.op)
            FOP_SPLIT: begin
                if (sel) begin
                    blk_next.offset = blk_reg.offset + cmd.need[31:0];
                    blk_next.size   = blk_reg.size - cmd.need;
                end
            end
            FOP_TAKE: begin
                if (sel || sel_seen) begin
                    blk_next = next_blk;
                end
            end
            FOP_PUSH: begin
                if (is_first) begin
                    blk_next.valid  = 1'b1;
                    blk_next.offset = cmd.push_offset;
                    blk_next.size   = cmd.push_size;
                end else if (prev_blk.valid) begin
                    blk_next = prev_blk;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blk_reg.valid  <= rst_valid;
            blk_reg.offset <= '0;
            blk_reg.size   <= rst_size;
        end else begin
            blk_reg <= blk_next;
        end
    end

endmodule

@@ rtl/core/fffl_slot_cell.sv @@
// one object slot: key, placement and sizes
// depends on fffl_pkg
module fffl_slot_cell (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        wr,
    input  logic        clr,
    input  logic [63:0] wr_key,
    input  logic [31:0] wr_offset,
    input  logic [32:0] wr_req,
    input  logic [32:0] wr_granted,
    input  logic [63:0] key,
    output logic        valid,
    output logic        hit,
    output logic [31:0] offset,
    output logic [32:0] req_size,
    output logic [32:0] granted
);
    import fffl_pkg::*;

    logic        valid_reg;
    logic [63:0] key_reg;
    logic [31:0] offset_reg;
    logic [32:0] req_reg, gr_reg;

    assign valid    = valid_reg;
    assign hit      = valid_reg && (key_reg == key);
    assign offset   = offset_reg;
    assign req_size = req_reg;
    assign granted  = gr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (wr) begin
            valid_reg <= 1'b1;
        end else if (clr) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr) begin
            key_reg    <= wr_key;
            offset_reg <= wr_offset;
            req_reg    <= wr_req;
            gr_reg     <= wr_granted;
        end
    end

endmodule

@@ rtl/core/first_fit_free_list_object_table_unit.sv @@
// top level: first-fit free-list object table
// depends on fffl_pkg, fffl_free_cell, fffl_slot_cell
//
// channel  dir  ports        payload
// s_axis   in   s_tvalid..   tdata: action[1:0], object_id[65:2], req_size[98:66]
// m_axis   out  m_tvalid..   tdata: status, found, obj_offset, obj_size, live_objects
//
// each transaction steps through accept, register the slot and cell searches,
// resolve and update the row of cells, present the result
// the cell row shifts one position per cycle-wide update, so split, take and
// push all land in the update cycle
// reset clears slot valid bits and loads one free block covering the region
// a stalled result holds the block; the next transaction waits until it is taken
module first_fit_free_list_object_table_unit #(
    parameter int          SLOTS        = 64,
    parameter logic [32:0] REGION_BYTES = 33'h1_0000_0000,
    parameter int          MIN_BLOCK    = 16,
    parameter int          FREE_CELLS   = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,  // action, object_id, req_size, zero fill
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [79:0]  m_tdata   // status, found, obj_offset, obj_size, live_objects
);
    import fffl_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FW = $clog2(FREE_CELLS);
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_UPDATE, S_OUT} state_t;

    state_t      state_reg;
    logic [1:0]  act_reg;
    logic [63:0] key_reg;
    logic [32:0] req_reg, need_reg;
    logic [2:0]  status_reg;
    logic        found_reg;
    logic [31:0] offs_reg;
    logic [32:0] size_reg;
    logic [CW-1:0] count_reg;

    // search results registered in S_SEARCH
    logic          fit_any_reg, free_slot_any_reg, hit_any_reg, full_reg;
    logic [FW-1:0] fit_idx_reg;
    logic [SW-1:0] free_idx_reg, hit_idx_reg;

    free_blk_t blks [FREE_CELLS];
    logic      fits [FREE_CELLS];
    logic      sel  [FREE_CELLS];
    logic      seen [FREE_CELLS];
    free_cmd_t cmd;

    logic        s_valid_v [SLOTS];
    logic        s_hit     [SLOTS];
    logic [31:0] s_off     [SLOTS];
    logic [32:0] s_req     [SLOTS];
    logic [32:0] s_gr      [SLOTS];
    logic        s_wr      [SLOTS];
    logic        s_clr     [SLOTS];

    free_blk_t fit_blk;
    logic      do_put, do_remove;
    logic [32:0] rem;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {4'd0, 7'(count_reg), size_reg, offs_reg, found_reg, status_reg};

    // first-fit selection in the cell row
    assign fit_blk = blks[fit_idx_reg];
    assign rem     = fit_blk.size - need_reg;

    always_comb begin
        do_put    = (state_reg == S_UPDATE) && (act_reg == ACT_PUT) && (req_reg != '0)
                    && fit_any_reg && free_slot_any_reg;
        do_remove = (state_reg == S_UPDATE) && (act_reg == ACT_REMOVE) && hit_any_reg
                    && !full_reg;
        cmd.need        = need_reg;
        cmd.push_offset = s_off[hit_idx_reg];
        cmd.push_size   = s_gr[hit_idx_reg];
        if (do_put) begin
            cmd.op = (rem >= 33'(MIN_BLOCK)) ? FOP_SPLIT : FOP_TAKE;
        end else if (do_remove) begin
            cmd.op = FOP_PUSH;
        end else begin
            cmd.op = FOP_NONE;
        end
    end

    for (genvar c = 0; c < FREE_CELLS; c++) begin : g_cell
        free_blk_t nb;
        if (c + 1 < FREE_CELLS) begin : g_nx
            assign nb = blks[c+1];
        end else begin : g_last
            assign nb = '0;
        end
        assign sel[c]  = (FW'(c) == fit_idx_reg);
        if (c == 0) begin : g_s0
            assign seen[c] = 1'b0;
        end else begin : g_sn
            assign seen[c] = seen[c-1] | sel[c-1];
        end
        fffl_free_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .rst_valid (c == 0),
            .rst_size  ((c == 0) ? REGION_BYTES : 33'd0),
            .cmd       (cmd),
            .sel       (sel[c]),
            .sel_seen  (seen[c]),
            .prev_blk  ((c == 0) ? free_blk_t'('0) : blks[(c == 0) ? 0 : c-1]),
            .next_blk  (nb),
            .is_first  (c == 0),
            .blk       (blks[c]),
            .fits      (fits[c])
        );
    end

    for (genvar k = 0; k < SLOTS; k++) begin : g_slot
        assign s_wr[k]  = do_put && (SW'(k) == free_idx_reg);
        assign s_clr[k] = do_remove && (SW'(k) == hit_idx_reg);
        fffl_slot_cell u_slot (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .wr         (s_wr[k]),
            .clr        (s_clr[k]),
            .wr_key     (key_reg),
            .wr_offset  (fit_blk.offset),
            .wr_req     (req_reg),
            .wr_granted ((rem >= 33'(MIN_BLOCK)) ? need_reg : fit_blk.size),
            .key        (key_reg),
            .valid      (s_valid_v[k]),
            .hit        (s_hit[k]),
            .offset     (s_off[k]),
            .req_size   (s_req[k]),
            .granted    (s_gr[k])
        );
    end

    // priority searches, registered before use
    logic          fit_any, fslot_any, hit_any;
    logic [FW-1:0] fit_idx;
    logic [SW-1:0] fslot_idx, hit_idx;
    always_comb begin
        fit_any = 1'b0; fit_idx = '0;
        for (int c = FREE_CELLS - 1; c >= 0; c--) begin
            if (fits[c]) begin
                fit_any = 1'b1;
                fit_idx = FW'(c);
            end
        end
        fslot_any = 1'b0; fslot_idx = '0;
        hit_any = 1'b0; hit_idx = '0;
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (!s_valid_v[k]) begin
                fslot_any = 1'b1;
                fslot_idx = SW'(k);
            end
            if (s_hit[k]) begin
                hit_any = 1'b1;
                hit_idx = SW'(k);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        act_reg   <= s_tdata[1:0];
                        key_reg   <= s_tdata[65:2];
                        req_reg   <= s_tdata[98:66];
                        need_reg  <= (s_tdata[98:66] < 33'(MIN_BLOCK)) ? 33'(MIN_BLOCK)
                                                                     : s_tdata[98:66];
                        state_reg <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    fit_any_reg       <= fit_any;
                    fit_idx_reg       <= fit_idx;
                    free_slot_any_reg <= fslot_any;
                    free_idx_reg      <= fslot_idx;
                    hit_any_reg       <= hit_any;
                    hit_idx_reg       <= hit_idx;
                    full_reg          <= blks[FREE_CELLS-1].valid;
                    state_reg         <= S_UPDATE;
                end
                S_UPDATE: begin
                    status_reg <= ST_OK;
                    found_reg  <= 1'b0;
                    offs_reg   <= '0;
                    size_reg   <= '0;
                    case (act_reg)
                        ACT_PUT: begin
                            if (req_reg == '0) begin
                                status_reg <= ST_ZERO_SIZE;
                            end else if (!fit_any_reg) begin
                                status_reg <= ST_NO_SPACE;
                            end else if (!free_slot_any_reg) begin
                                status_reg <= ST_NO_SLOT;
                            end else begin
                                offs_reg  <= fit_blk.offset;
                                count_reg <= count_reg + CW'(1);
                            end
                        end
                        ACT_LOOKUP, ACT_REMOVE: begin
                            if (!hit_any_reg) begin
                                status_reg <= ST_NOT_FOUND;
                            end else if (act_reg == ACT_REMOVE && full_reg) begin
                                status_reg <= ST_LIST_FULL;
                                found_reg  <= 1'b1;
                            end else begin
                                found_reg <= 1'b1;
                                offs_reg  <= s_off[hit_idx_reg];
                                size_reg  <= s_req[hit_idx_reg];
                                if (act_reg == ACT_REMOVE) begin
                                    count_reg <= count_reg - CW'(1);
                                end
                            end
                        end
                        default: ;
                    endcase
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (m_tready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // a put can only grant when both searches succeeded
    a_put_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        do_put |-> (fit_any_reg && free_slot_any_reg))
        else $error("put without fit or slot");
    // result holds while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("result changed under stall");
    // the head cell is valid right after a push
    a_push: assert property (@(posedge aclk) disable iff (!aresetn)
        do_remove |=> blks[0].valid)
        else $error("push lost");
    // object count never exceeds slot count
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(SLOTS))
        else $error("object count overflow");

endmodule

@@ dv/tb.sv @@
// self-checking testbench for first_fit_free_list_object_table_unit
// depends on fffl_pkg and the rtl of the unit; a scoreboard class mirrors the
// slot table and the free-block row and checks every result transaction
module tb;
    import fffl_pkg::*;

    localparam int NUM_SLOTS = 64;
    localparam int NUM_CELLS = 64;
    localparam logic [32:0] REGION = 33'h1_0000_0000;
    localparam logic [32:0] MIN_BLK = 33'd16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD = 300;

    typedef struct packed {
        logic [2:0]  status;
        logic        found;
        logic [31:0] offset;
        logic [32:0] size;
        logic [6:0]  count;
    } table_result_t;

    class table_scoreboard;
        logic        slot_used [NUM_SLOTS];
        logic [63:0] slot_key [NUM_SLOTS];
        logic [31:0] slot_base [NUM_SLOTS];
        logic [32:0] slot_req [NUM_SLOTS];
        logic [32:0] slot_grant [NUM_SLOTS];
        logic        cell_valid [NUM_CELLS];
        logic [31:0] cell_offset [NUM_CELLS];
        logic [32:0] cell_size [NUM_CELLS];
        int          live;
        table_result_t expected_results[$];
        int          mismatches;

        function void clear();
            for (int i = 0; i < NUM_SLOTS; i++) begin
                slot_used[i] = 1'b0;
                slot_key[i] = '0;
                slot_base[i] = '0;
                slot_req[i] = '0;
                slot_grant[i] = '0;
            end
            for (int i = 0; i < NUM_CELLS; i++) begin
                cell_valid[i] = 1'b0;
                cell_offset[i] = '0;
                cell_size[i] = '0;
            end
            cell_valid[0] = 1'b1;
            cell_size[0] = REGION;
            live = 0;
            mismatches = 0;
        endfunction

        function int match_slot(logic [63:0] key);
            int hit;
            hit = -1;
            for (int i = NUM_SLOTS - 1; i >= 0; i--)
                if (slot_used[i] && slot_key[i] == key) hit = i;
            return hit;
        endfunction

        function void note_request(logic [1:0] act, logic [63:0] key, logic [32:0] req);
            table_result_t r;
            logic [32:0] need;
            logic [32:0] bsz;
            logic [31:0] base;
            int used;
            int fit_cell;
            int s;
            r = '0;
            used = 0;
            while (used < NUM_CELLS && cell_valid[used]) used++;
            case (act)
                ACT_PUT: begin
                    need = (req < MIN_BLK) ? MIN_BLK : req;
                    fit_cell = -1;
                    for (int c = 0; c < used; c++)
                        if (fit_cell < 0 && cell_size[c] >= need) fit_cell = c;
                    s = -1;
                    for (int k = 0; k < NUM_SLOTS; k++)
                        if (s < 0 && !slot_used[k]) s = k;
                    if (req == 0) r.status = ST_ZERO_SIZE;
                    else if (fit_cell < 0) r.status = ST_NO_SPACE;
                    else if (s < 0) r.status = ST_NO_SLOT;
                    else begin
                        base = cell_offset[fit_cell];
                        bsz = cell_size[fit_cell];
                        if (bsz - need >= MIN_BLK) begin
                            slot_grant[s] = need;
                            cell_offset[fit_cell] = base + need[31:0];
                            cell_size[fit_cell] = bsz - need;
                        end else begin
                            // whole block granted, later cells close the gap
                            slot_grant[s] = bsz;
                            for (int c = fit_cell; c + 1 < used; c++) begin
                                cell_offset[c] = cell_offset[c + 1];
                                cell_size[c] = cell_size[c + 1];
                            end
                            cell_valid[used - 1] = 1'b0;
                            cell_offset[used - 1] = '0;
                            cell_size[used - 1] = '0;
                        end
                        slot_used[s] = 1'b1;
                        slot_key[s] = key;
                        slot_base[s] = base;
                        slot_req[s] = req;
                        live++;
                        r.offset = base;
                    end
                end
                ACT_LOOKUP: begin
                    s = match_slot(key);
                    if (s < 0) r.status = ST_NOT_FOUND;
                    else begin
                        r.found = 1'b1;
                        r.offset = slot_base[s];
                        r.size = slot_req[s];
                    end
                end
                ACT_REMOVE: begin
                    s = match_slot(key);
                    if (s < 0) r.status = ST_NOT_FOUND;
                    else if (used >= NUM_CELLS) begin
                        r.status = ST_LIST_FULL;
                        r.found = 1'b1;
                    end else begin
                        for (int c = used; c > 0; c--) begin
                            cell_offset[c] = cell_offset[c - 1];
                            cell_size[c] = cell_size[c - 1];
                        end
                        cell_valid[used] = 1'b1;
                        cell_offset[0] = slot_base[s];
                        cell_size[0] = slot_grant[s];
                        r.found = 1'b1;
                        r.offset = slot_base[s];
                        r.size = slot_req[s];
                        slot_used[s] = 1'b0;
                        live--;
                    end
                end
                default: ;
            endcase
            r.count = live[6:0];
            expected_results.push_back(r);
        endfunction

        function void check_result(table_result_t got);
            table_result_t exp;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: %p", got);
                return;
            end
            exp = expected_results.pop_front();
            if (got.status !== exp.status || got.found !== exp.found ||
                got.offset !== exp.offset || got.size !== exp.size ||
                got.count !== exp.count) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected %p, got %p", exp, got);
            end
        endfunction
    endclass

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [103:0] s_tdata = '0;   // action, object_id, req_size, zero fill
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [79:0]  m_tdata;        // status, found, obj_offset, obj_size, live_objects

    table_scoreboard sb;
    bit  hold_long = 1'b0;
    bit  timed_out = 1'b0;
    int  idle_cycles = 0;

    always #4 aclk = ~aclk;

    first_fit_free_list_object_table_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_request(s_tdata[1:0], s_tdata[65:2], s_tdata[98:66]);
        if (aresetn && m_tvalid && m_tready)
            sb.check_result({m_tdata[2:0], m_tdata[3], m_tdata[35:4],
                             m_tdata[68:36], m_tdata[75:69]});
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    always @(posedge aclk) begin
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result side: random stall per transaction, one long hold when asked
    initial begin
        int n;
        @(posedge aresetn);
        forever begin
            if (hold_long) begin
                n = LONG_HOLD;
                hold_long = 1'b0;
            end else if ($urandom_range(0, 3) == 0) n = 0;
            else n = $urandom_range(0, 8);
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_request(logic [1:0] act, logic [63:0] key, logic [32:0] req,
                                int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, req, key, act};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_random_gap(logic [1:0] act, logic [63:0] key, logic [32:0] req);
        send_request(act, key, req, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_results.size() != 0) @(posedge aclk);
    endtask

    initial begin
        int sel;
        logic [63:0] key;
        logic [32:0] req;
        logic [1:0] act;
        sb = new();
        sb.clear();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed corner cases
        send_random_gap(ACT_PUT, 64'd1, 33'd0);
        send_random_gap(ACT_LOOKUP, 64'd5, 33'd0);
        send_random_gap(ACT_REMOVE, 64'd5, 33'd0);
        send_random_gap(2'd3, 64'hFFFF_FFFF_FFFF_FFFF, 33'h1_FFFF_FFFF);
        send_random_gap(ACT_PUT, 64'hFFFF_FFFF_FFFF_FFFF, REGION);   // whole region
        send_random_gap(ACT_PUT, 64'd2, 33'd1);                      // empty free list
        send_random_gap(ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 33'd0);
        send_random_gap(ACT_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 33'd0);
        send_random_gap(ACT_PUT, 64'd3, 33'h1_FFFF_FFFF);            // oversized
        // fill every slot, then overflow the slot table
        for (int i = 0; i < NUM_SLOTS; i++)
            send_request(ACT_PUT, 64'd100 + i, 33'(i % 20 + 1), 0);
        send_random_gap(ACT_PUT, 64'd99, 33'd16);
        // removes grow the free row until it is full
        for (int i = 0; i < NUM_SLOTS; i++)
            send_request(ACT_REMOVE, 64'd100 + i, 33'd0, $urandom_range(0, 2));
        send_random_gap(ACT_LOOKUP, 64'd163, 33'd0);
        send_random_gap(ACT_PUT, 64'd163, 33'd20);                   // duplicate key
        send_random_gap(ACT_LOOKUP, 64'd163, 33'd0);
        send_random_gap(ACT_REMOVE, 64'd163, 33'd0);
        drain_results();

        for (int i = 0; i < 460; i++) begin
            if (i == 150) hold_long = 1'b1;
            if (i == 350) drain_results();
            sel = $urandom_range(0, 99);
            if (sel < 45) act = ACT_PUT;
            else if (sel < 72) act = ACT_REMOVE;
            else if (sel < 95) act = ACT_LOOKUP;
            else act = 2'd3;
            if ($urandom_range(0, 9) == 0) key = {$urandom, $urandom};
            else key = 64'($urandom_range(0, 79));
            sel = $urandom_range(0, 99);
            if (sel < 80) req = 33'($urandom_range(0, 64));
            else if (sel < 92) req = 33'($urandom_range(65, 100000));
            else if (sel < 97) req = {1'($urandom_range(0, 1)), $urandom};
            else req = REGION;
            send_random_gap(act, key, req);
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.mismatches == 0 && !timed_out)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
